// ===== rtl/mkd_pkg.sv =====
// ----------------------------------------------------------------------------
// mkd_pkg
// Shared sizes, register map and payload layouts for the multi-key debouncer.
// ----------------------------------------------------------------------------
package mkd_pkg;

  // Number of debounced keys. Keys beyond the field width see a pressed pin,
  // cannot be taken and are not reported.
  localparam int NUM_KEYS = 4;

  // Width of the per-key mask fields on the stream ports.
  localparam int FIELD_W  = 4;
  localparam int TIME_W   = 32;
  localparam int DBT_W    = 16;

  // Stream payload widths (packed fields; tdata padded to whole bytes).
  localparam int S_DATA_W = 48;
  localparam int S_USER_W = 1;
  localparam int M_DATA_W = 16;

  // Configuration port.
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;
  localparam logic [PADDR_W-1:0] REG_DEBOUNCE_TIME = 3'd0;
  localparam logic [DBT_W-1:0]   DEBOUNCE_RESET    = 16'd20;

  // Input beat, as held in the input register.
  typedef struct packed {
    logic                sample_valid;
    logic [FIELD_W-1:0]  raw_levels;
    logic [TIME_W-1:0]   now_time;
    logic [FIELD_W-1:0]  take_press_mask;
    logic [FIELD_W-1:0]  take_release_mask;
  } mkd_in_t;

  // Result beat, as held in the result register.
  typedef struct packed {
    logic [FIELD_W-1:0] release_flags;
    logic [FIELD_W-1:0] press_flags;
    logic [FIELD_W-1:0] stable_mask;
  } mkd_out_t;

endpackage

// ===== rtl/multi_key_debouncer_events_core.sv =====
// ----------------------------------------------------------------------------
// multi_key_debouncer_events_core
// Debounces active-low keys against a wrapping millisecond time stamp and
// keeps sticky press and release events until they are taken.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake              Payload
//  s_*       in         s_tvalid / s_tready    s_tdata: raw_levels, now_time,
//                                              take_press_mask,
//                                              take_release_mask; s_tuser:
//                                              sample_valid
//  m_*       out        m_tvalid / m_tready    m_tdata: stable_mask,
//                                              press_flags, release_flags
//  APB       in         psel/penable/pready    debounce_time at address 0
//
//  Every beat passes from the input register through the per-key
//  update into the result register. A new beat is accepted every
//  cycle while m_tready is high; the rate is set by the single
//  32-bit subtract and compare that each key performs per beat.
//  A stalled m_tready holds the result register, and the input register
//  then fills and drops s_tready until the result is taken.
//  The synchronous reset releases all keys, zeroes the time stamps, clears
//  every event flag and loads the debounce time of 20 ms.
//
module multi_key_debouncer_events_core
  import mkd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,

  // Input stream.
  input  logic                s_tvalid,
  output logic                s_tready,
  // [3:0] raw_levels, [35:4] now_time, [39:36] take_press_mask,
  // [43:40] take_release_mask, [47:44] zero.
  input  logic [S_DATA_W-1:0] s_tdata,
  // [0] sample_valid.
  input  logic [S_USER_W-1:0] s_tuser,

  // Result stream.
  output logic                m_tvalid,
  input  logic                m_tready,
  // [3:0] stable_mask, [7:4] press_flags, [11:8] release_flags,
  // [15:12] zero.
  output logic [M_DATA_W-1:0] m_tdata,

  // Configuration port.
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  // --------------------------------------------------------------------------
  // Configuration register. Writes land at the access phase; any address
  // other than the debounce time register is ignored and reads as zero.
  // --------------------------------------------------------------------------
  logic [DBT_W-1:0] debounce_time;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_time <= DEBOUNCE_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr == REG_DEBOUNCE_TIME) begin
      debounce_time <= pwdata[DBT_W-1:0];
    end
  end

  always_comb begin
    if (paddr == REG_DEBOUNCE_TIME) begin
      prdata = {{(PDATA_W-DBT_W){1'b0}}, debounce_time};
    end else begin
      prdata = '0;
    end
  end

  // --------------------------------------------------------------------------
  // Handshake. The input register moves into the result register whenever
  // the result register is empty or is being drained in the same cycle.
  // --------------------------------------------------------------------------
  logic    in_valid;
  mkd_in_t in_reg;
  logic    out_valid;
  mkd_out_t out_reg;
  logic    s_beat;
  logic    advance;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign s_beat   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_beat) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (s_beat) begin
      in_reg.sample_valid      <= s_tuser[0];
      in_reg.raw_levels        <= s_tdata[FIELD_W-1:0];
      in_reg.now_time          <= s_tdata[FIELD_W+TIME_W-1:FIELD_W];
      in_reg.take_press_mask   <= s_tdata[2*FIELD_W+TIME_W-1:FIELD_W+TIME_W];
      in_reg.take_release_mask <= s_tdata[3*FIELD_W+TIME_W-1:2*FIELD_W+TIME_W];
    end
  end

  // --------------------------------------------------------------------------
  // Per-key state.
  // --------------------------------------------------------------------------
  logic [NUM_KEYS-1:0] last_raw, last_raw_next;
  logic [NUM_KEYS-1:0] stable_level, stable_level_next;
  logic [NUM_KEYS-1:0] press_pending, press_pending_next;
  logic [NUM_KEYS-1:0] release_pending, release_pending_next;
  logic [TIME_W-1:0]   change_time      [NUM_KEYS];
  logic [TIME_W-1:0]   change_time_next [NUM_KEYS];

  // Flags after this beat's sample, before its take masks clear them.
  logic [NUM_KEYS-1:0] press_seen;
  logic [NUM_KEYS-1:0] release_seen;

  // Pins are active low. Keys past the field width see a pressed pin and
  // have no take bit.
  logic [NUM_KEYS-1:0] key_pressed;
  logic [NUM_KEYS-1:0] take_press;
  logic [NUM_KEYS-1:0] take_release;

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key_in
    if (k < FIELD_W) begin : g_pin
      assign key_pressed[k]  = ~in_reg.raw_levels[k];
      assign take_press[k]   = in_reg.take_press_mask[k];
      assign take_release[k] = in_reg.take_release_mask[k];
    end else begin : g_nopin
      assign key_pressed[k]  = 1'b1;
      assign take_press[k]   = 1'b0;
      assign take_release[k] = 1'b0;
    end
  end

  // A raw change only restarts that key's timer. A steady raw level that
  // disagrees with the stable level takes over once the elapsed time,
  // computed modulo 2^32, reaches the debounce time.
  always_comb begin
    logic [TIME_W-1:0] elapsed;
    last_raw_next     = last_raw;
    stable_level_next = stable_level;
    press_seen        = press_pending;
    release_seen      = release_pending;
    elapsed           = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      change_time_next[k] = change_time[k];
      elapsed = in_reg.now_time - change_time[k];
      if (in_reg.sample_valid) begin
        if (key_pressed[k] != last_raw[k]) begin
          last_raw_next[k]    = key_pressed[k];
          change_time_next[k] = in_reg.now_time;
        end else if (key_pressed[k] != stable_level[k] &&
                     elapsed >= {{(TIME_W-DBT_W){1'b0}}, debounce_time}) begin
          stable_level_next[k] = key_pressed[k];
          if (key_pressed[k]) begin
            press_seen[k] = 1'b1;
          end else begin
            release_seen[k] = 1'b1;
          end
        end
      end
    end
    press_pending_next   = press_seen & ~take_press;
    release_pending_next = release_seen & ~take_release;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_raw        <= '0;
      stable_level    <= '0;
      press_pending   <= '0;
      release_pending <= '0;
      for (int k = 0; k < NUM_KEYS; k++) begin
        change_time[k] <= '0;
      end
    end else if (advance) begin
      last_raw        <= last_raw_next;
      stable_level    <= stable_level_next;
      press_pending   <= press_pending_next;
      release_pending <= release_pending_next;
      for (int k = 0; k < NUM_KEYS; k++) begin
        change_time[k] <= change_time_next[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result register. Only the keys that fit the field width are reported.
  // --------------------------------------------------------------------------
  mkd_out_t result;

  for (genvar b = 0; b < FIELD_W; b++) begin : g_report
    if (b < NUM_KEYS) begin : g_key
      assign result.stable_mask[b]   = stable_level_next[b];
      assign result.press_flags[b]   = press_seen[b];
      assign result.release_flags[b] = release_seen[b];
    end else begin : g_nokey
      assign result.stable_mask[b]   = 1'b0;
      assign result.press_flags[b]   = 1'b0;
      assign result.release_flags[b] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_reg <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(M_DATA_W-3*FIELD_W){1'b0}}, out_reg};

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
`ifndef SYNTHESIS
  // A beat never moves into a result register that still holds an untaken
  // result.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    advance |-> (!out_valid || m_tready))
    else $error("result register overwritten while stalled");

  // The stable levels only move on a beat that carries a sample.
  a_stable_needs_sample: assert property (@(posedge clk) disable iff (rst)
    !(advance && in_reg.sample_valid) |=> $stable(stable_level))
    else $error("stable level changed without a sample");

  // A newly raised press flag belongs to a key that is now pressed.
  a_press_matches_level: assert property (@(posedge clk) disable iff (rst)
    ((press_pending & ~$past(press_pending) & ~stable_level) == '0))
    else $error("press event raised for a released key");

  // A newly raised release flag belongs to a key that is now released.
  a_release_matches_level: assert property (@(posedge clk) disable iff (rst)
    ((release_pending & ~$past(release_pending) & stable_level) == '0))
    else $error("release event raised for a pressed key");
`endif

endmodule
